// ----- design/eqh_pkg.sv -----
// shared constants, codes and types of the equal-width histogram
package eqh_pkg;

    localparam int DEF_MAX_BINS     = 64;
    localparam int DEF_COUNT_WIDTH  = 32;
    localparam int DEF_SAMPLE_WIDTH = 16;

    localparam int FUNC_W    = 2;
    localparam int INDEX_W   = 6;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int BINS_W    = 7;

    localparam logic [CFG_DAT_W-1:0] RANGE_LOW_RST  = 16'd0;
    localparam logic [CFG_DAT_W-1:0] RANGE_HIGH_RST = 16'd255;
    localparam logic [BINS_W-1:0]    BIN_COUNT_RST  = 7'd64;

    typedef enum logic [FUNC_W-1:0] {
        FN_ACCUM = 2'd0,
        FN_READ  = 2'd1,
        FN_CLEAR = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW  = 2'd0,
        REG_HIGH = 2'd1,
        REG_BINS = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_all;
    } store_ctl_t;

endpackage

// ----- design/eqh_in_if.sv -----
// request channel: function code, sample and bin index
interface eqh_in_if #(
    parameter int SAMPLE_WIDTH = eqh_pkg::DEF_SAMPLE_WIDTH
);
    logic                             valid;
    logic                             ready;
    logic [eqh_pkg::FUNC_W-1:0]       func;
    logic signed [SAMPLE_WIDTH-1:0]   sample;
    logic [eqh_pkg::INDEX_W-1:0]      bin_index;

    modport source (output valid, output func, output sample, output bin_index, input ready);
    modport sink   (input valid, input func, input sample, input bin_index, output ready);
endinterface

// ----- design/eqh_out_if.sv -----
// result channel: bin count
interface eqh_out_if;
    logic                       valid;
    logic                       ready;
    logic [eqh_pkg::OUT_W-1:0]  count;

    modport source (output valid, output count, input ready);
    modport sink   (input valid, input count, output ready);
endinterface

// ----- design/eqh_cfg_if.sv -----
// configuration write channel: register index and data
interface eqh_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [eqh_pkg::CFG_IDX_W-1:0]  index;
    logic [eqh_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/eqh_mul.sv -----
// bit-serial shift-add multiplier, one multiplier bit per cycle
module eqh_mul #(
    parameter int SW = eqh_pkg::DEF_SAMPLE_WIDTH,
    parameter int BW = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [SW+BW-1:0] prod
);
    import eqh_pkg::*;

    localparam int PW  = SW + BW;
    localparam int SCW = (BW > 1) ? $clog2(BW) : 1;

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [SCW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0]  acc_reg, acc_next;
    logic [PW-1:0]  m_reg, m_next;
    logic [BW-1:0]  mb_reg, mb_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        m_next    = m_reg;
        mb_next   = mb_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = SCW'(BW - 1);
            acc_next  = '0;
            m_next    = PW'(a);
            mb_next   = b;
        end
        else if (busy_reg)
        begin
            if (mb_reg[0])
            begin
                acc_next = acc_reg + m_reg;
            end
            m_next  = m_reg << 1;
            mb_next = mb_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        m_reg   <= m_next;
        mb_reg  <= mb_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- design/eqh_div.sv -----
// restoring divider, one quotient bit per cycle
module eqh_div #(
    parameter int NW = 23,
    parameter int DW = eqh_pkg::DEF_SAMPLE_WIDTH,
    parameter int QW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [QW-1:0] quo
);
    import eqh_pkg::*;

    localparam int SCW = (QW > 1) ? $clog2(QW) : 1;

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [SCW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]  rem_reg, rem_next;
    logic [NW-1:0]  dsh_reg, dsh_next;
    logic [QW-1:0]  q_reg, q_next;
    logic           ge;

    assign ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = SCW'(QW - 1);
            rem_next  = num;
            dsh_next  = NW'(den) << (QW - 1);
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = QW'({q_reg, ge});
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ----- design/eqh_store.sv -----
// bin counter memory with per-bin valid bits, registered read
module eqh_store #(
    parameter int MAX_BINS    = eqh_pkg::DEF_MAX_BINS,
    parameter int COUNT_WIDTH = eqh_pkg::DEF_COUNT_WIDTH,
    parameter int IW          = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  eqh_pkg::store_ctl_t    ctl,
    input  logic [IW-1:0]          rd_addr,
    input  logic [IW-1:0]          wr_addr,
    input  logic [COUNT_WIDTH-1:0] wr_data,
    output logic [COUNT_WIDTH-1:0] rd_data
);
    import eqh_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [MAX_BINS];
    logic [MAX_BINS-1:0]    vld_reg;
    logic [COUNT_WIDTH-1:0] rd_mem_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr_all)
            begin
                vld_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_mem_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_mem_reg : '0;

endmodule

// ----- design/equal_width_histogram.sv -----
// top level of the equal-width histogram
//
//  channel  dir   fields                       transfer when
//  item     in    func, sample, bin_index      item.valid & item.ready
//  rsp      out   count                        rsp.valid & rsp.ready
//  cfg      in    index, data                  cfg.valid & cfg.ready
//
// one request at a time; accumulate runs the serial multiplier, then the serial divider,
// one bit a cycle each over BW = clog2(MAX_BINS+1) bits; a read passes the registered store
// read to the output register; an out-of-range sample ends at the range check, clear and
// unused in idle; reset clears the bin valid bits at once, no sweep; the output register
// frees the request side while a result waits, a stalled result holds only the next read
module equal_width_histogram #(
    parameter int MAX_BINS     = eqh_pkg::DEF_MAX_BINS,
    parameter int COUNT_WIDTH  = eqh_pkg::DEF_COUNT_WIDTH,
    parameter int SAMPLE_WIDTH = eqh_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic     clk,
    input  logic     rst_n,
    eqh_in_if.sink   item,
    eqh_out_if.source rsp,
    eqh_cfg_if.sink  cfg
);
    import eqh_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int BW = $clog2(MAX_BINS + 1);
    localparam int IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int PW = SW + BW;

    state_t state_reg, state_next;

    logic signed [SW-1:0] lo_reg, lo_next;
    logic signed [SW-1:0] hi_reg, hi_next;
    logic [BINS_W-1:0]    bc_reg, bc_next;

    logic signed [SW-1:0]   sample_reg;
    logic [BW-1:0]          b_reg;
    logic [IW-1:0]          idx_reg;
    logic                   oob_reg;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       count_reg;

    logic                   item_xfer;
    logic                   smp_hit;
    logic [SW-1:0]          diff;
    logic [SW-1:0]          span;
    logic [BW-1:0]          b_calc;
    logic                   mul_start, mul_done;
    logic [PW-1:0]          prod;
    logic                   div_start, div_done;
    logic [BW-1:0]          quo;
    logic [IW-1:0]          idx_calc;
    logic                   slot_free;
    logic                   load_out;
    store_ctl_t             st_ctl;
    logic [IW-1:0]          rd_addr;
    logic [COUNT_WIDTH-1:0] rd_count;
    logic [COUNT_WIDTH-1:0] wr_count;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        bc_next = bc_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_LOW:  lo_next = SW'(cfg.data);
                REG_HIGH: hi_next = SW'(cfg.data);
                REG_BINS: bc_next = BINS_W'(cfg.data);
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= SW'(RANGE_LOW_RST);
            hi_reg <= SW'(RANGE_HIGH_RST);
            bc_reg <= BIN_COUNT_RST;
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            bc_reg <= bc_next;
        end
    end

    // range check and bin setup
    assign item_xfer = item.valid && item.ready;
    assign smp_hit   = (hi_reg > lo_reg) && (sample_reg >= lo_reg) && (sample_reg <= hi_reg);
    assign diff      = SW'(sample_reg - lo_reg);
    assign span      = SW'(hi_reg - lo_reg);

    always_comb
    begin
        if (bc_reg == '0)
        begin
            b_calc = BW'(1);
        end
        else if (32'(bc_reg) > MAX_BINS)
        begin
            b_calc = BW'(MAX_BINS);
        end
        else
        begin
            b_calc = BW'(bc_reg);
        end
    end

    assign idx_calc = (quo >= b_reg) ? IW'(b_reg - BW'(1)) : IW'(quo);

    eqh_mul #(
        .SW (SW),
        .BW (BW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (diff),
        .b     (b_calc),
        .done  (mul_done),
        .prod  (prod)
    );

    eqh_div #(
        .NW (PW),
        .DW (SW),
        .QW (BW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod),
        .den   (span),
        .done  (div_done),
        .quo   (quo)
    );

    assign wr_count = (rd_count == '1) ? rd_count : rd_count + 1'b1;

    eqh_store #(
        .MAX_BINS    (MAX_BINS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .IW          (IW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (st_ctl),
        .rd_addr (rd_addr),
        .wr_addr (idx_reg),
        .wr_data (wr_count),
        .rd_data (rd_count)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    case (item.func)
                        FN_ACCUM: state_next = ST_CHECK;
                        FN_READ:  state_next = ST_RESULT;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CHECK:  state_next = smp_hit ? ST_MUL : ST_IDLE;
            ST_MUL:    state_next = mul_done ? ST_DIV : ST_MUL;
            ST_DIV:    state_next = div_done ? ST_UPDATE : ST_DIV;
            ST_UPDATE: state_next = ST_IDLE;
            ST_RESULT: state_next = slot_free ? ST_IDLE : ST_RESULT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // state outputs
    assign slot_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        item.ready     = 1'b0;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        load_out       = 1'b0;
        st_ctl         = '0;
        rd_addr        = IW'(item.bin_index);
        case (state_reg)
            ST_IDLE:
            begin
                item.ready     = 1'b1;
                st_ctl.rd_en   = item_xfer && (item.func == FN_READ);
                st_ctl.clr_all = item_xfer && (item.func == FN_CLEAR);
            end
            ST_CHECK:  mul_start = smp_hit;
            ST_MUL:    div_start = mul_done;
            ST_DIV:
            begin
                st_ctl.rd_en = div_done;
                rd_addr      = idx_calc;
            end
            ST_UPDATE: st_ctl.wr_en = 1'b1;
            ST_RESULT: load_out = slot_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            sample_reg <= item.sample;
            oob_reg    <= (32'(item.bin_index) >= MAX_BINS);
        end
        if (state_reg == ST_CHECK)
        begin
            b_reg <= b_calc;
        end
        if (st_ctl.rd_en && (state_reg == ST_DIV))
        begin
            idx_reg <= idx_calc;
        end
        if (load_out)
        begin
            count_reg <= oob_reg ? '0 : OUT_W'(rd_count);
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.count = count_reg;

`ifndef NO_ASSERTIONS
    a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside its state");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its state");

    a_bin_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> (BW'(idx_reg) < b_reg))
        else $error("update addresses a bin beyond those in use");

    a_read_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && (item.func == FN_READ)) |=> (state_reg == ST_RESULT))
        else $error("read request did not reach the result state");
`endif

endmodule
